// ===== design/afd_pkg.sv =====
// Shared constants, types and helper functions of the accelerometer fall detector.
package afd_pkg;

	// magnitude window
	localparam int WIN_LEN = 32;
	localparam int WIN_AW  = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
	localparam int FILL_W  = $clog2(WIN_LEN + 1);
	localparam int SUM_W   = 16 + WIN_AW;
	localparam int SUMSQ_W = 32 + WIN_AW;
	localparam int MUL_W   = 2 * SUM_W;

	// square root: one result bit per step over a 32-bit radicand
	localparam int ROOT_STEPS = 16;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	localparam logic [CFG_AW-1:0] REG_FREEFALL_LEVEL     = 3'd0;
	localparam logic [CFG_AW-1:0] REG_IMPACT_LEVEL       = 3'd1;
	localparam logic [CFG_AW-1:0] REG_IMPACT_WINDOW_MS   = 3'd2;
	localparam logic [CFG_AW-1:0] REG_STILLNESS_VARIANCE = 3'd3;
	localparam logic [CFG_AW-1:0] REG_STILLNESS_MS       = 3'd4;
	localparam logic [CFG_AW-1:0] REG_RECOVERY_MS        = 3'd5;

	// output phase codes
	localparam logic [1:0] CODE_IDLE      = 2'd0;
	localparam logic [1:0] CODE_FREEFALL  = 2'd1;
	localparam logic [1:0] CODE_IMPACT    = 2'd2;
	localparam logic [1:0] CODE_CONFIRMED = 2'd3;

	typedef struct packed {
		logic [15:0] freefall_level;
		logic [15:0] impact_level;
		logic [15:0] impact_window_ms;
		logic [31:0] stillness_variance;
		logic [15:0] stillness_ms;
		logic [15:0] recovery_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		freefall_level:     16'd2048,
		impact_level:       16'd10240,
		impact_window_ms:   16'd300,
		stillness_variance: 32'd4096,
		stillness_ms:       16'd2000,
		recovery_ms:        16'd15000
	};

	// detector phase
	typedef enum logic [3:0] {
		PH_IDLE      = 4'b0001,
		PH_FREEFALL  = 4'b0010,
		PH_IMPACT    = 4'b0100,
		PH_CONFIRMED = 4'b1000
	} phase_t;

	// sequencer
	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_SQ     = 10'b00_0000_0010,
		S_ROOT   = 10'b00_0000_0100,
		S_DECIDE = 10'b00_0000_1000,
		S_OSQ    = 10'b00_0001_0000,
		S_MSQ    = 10'b00_0010_0000,
		S_PUSH   = 10'b00_0100_0000,
		S_SSQ    = 10'b00_1000_0000,
		S_VAR    = 10'b01_0000_0000,
		S_EMIT   = 10'b10_0000_0000
	} ctl_t;

	function automatic logic [1:0] phase_code(phase_t p);
		logic [1:0] c;
		case (p)
			PH_IDLE:      c = CODE_IDLE;
			PH_FREEFALL:  c = CODE_FREEFALL;
			PH_IMPACT:    c = CODE_IMPACT;
			PH_CONFIRMED: c = CODE_CONFIRMED;
			default:      c = CODE_IDLE;
		endcase
		return c;
	endfunction

	// absolute value; the most negative count maps to 32768
	function automatic logic [15:0] abs16(logic signed [15:0] v);
		logic [15:0] r;
		r = v[15] ? (~v + 16'd1) : v;
		return r;
	endfunction

endpackage

// ===== design/accel_fall_detector.sv =====
// Top level of the accelerometer fall detector: serial magnitude, window variance, phase control.
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid / in_stall       req_type, accel_x/y/z, time_ms
//  out      source     out_valid / out_stall     detector_state, fall_flag, magnitude
//  cfg      sink       cfg_we                    cfg_index, cfg_data
//
// One beat at a time. A sample's result is registered once the sequencer has squared the axes
// and taken the square root, and in the impact phase updated the window; a clear's result goes
// straight to the output step. The next beat can be taken in the cycle after that. The work is
// done by the shift-add multiplier (one multiplier bit per cycle, for each axis square, window
// entry square and the window sum) and the square root (one result bit per cycle). Reset is
// asynchronous and needs no clearing pass. The next beat is taken while a result waits in the
// output register; a stalled output holds the sequencer in its final step.
module accel_fall_detector
	import afd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_AW-1:0]   cfg_index,
	input  logic [CFG_DW-1:0]   cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic signed [15:0]  accel_x,
	input  logic signed [15:0]  accel_y,
	input  logic signed [15:0]  accel_z,
	input  logic [31:0]         time_ms,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          detector_state,
	output logic                fall_flag,
	output logic [15:0]         magnitude
);

	localparam logic [MUL_W-1:0]  N_W      = MUL_W'(WIN_LEN);
	localparam logic [MUL_W-1:0]  NN_W     = MUL_W'(WIN_LEN * WIN_LEN);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WIN_LEN);
	localparam logic [FILL_W-1:0] FILL_PRE = FILL_W'(WIN_LEN - 1);
	localparam logic [WIN_AW-1:0] POS_MAX  = WIN_AW'(WIN_LEN - 1);
	localparam logic [3:0]        ITER_END = 4'(ROOT_STEPS - 1);

	cfg_t                 cfg_q;
	ctl_t                 st_q;
	phase_t               phase_q;
	logic [31:0]          ff_stamp_q;
	logic [31:0]          imp_stamp_q;
	logic [31:0]          still_stamp_q;
	logic                 still_trk_q;
	logic [FILL_W-1:0]    fill_q;
	logic [WIN_AW-1:0]    pos_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SUMSQ_W-1:0]   sumsq_q;
	logic [15:0]          window_q [WIN_LEN];
	logic [15:0]          old_q;
	logic signed [15:0]   ax_q [3];
	logic [1:0]           ax_idx_q;
	logic [31:0]          t_q;
	logic [MUL_W-1:0]     mul_a_q;
	logic [SUM_W-1:0]     mul_b_q;
	logic [MUL_W-1:0]     acc_q;
	logic [31:0]          rem_q;
	logic [31:0]          res_q;
	logic [31:0]          bit_q;
	logic [3:0]           iter_q;
	logic [15:0]          mag_q;
	logic                 out_valid_q;
	logic [1:0]           det_state_q;
	logic                 fall_q;
	logic [15:0]          mag_out_q;

	logic                 in_acc;
	logic                 mul_done;
	logic [MUL_W-1:0]     mul_acc_next;
	logic [32:0]          root_trial;
	logic                 root_take;
	logic [31:0]          res_next;
	logic [15:0]          ax_next;
	logic [SUM_W-1:0]     sum_push;
	logic                 fill_full;
	logic [MUL_W-1:0]     var_lhs;
	logic [MUL_W-1:0]     var_rhs;
	logic                 is_still;
	logic [31:0]          ff_gap;
	logic [31:0]          imp_gap;
	logic [31:0]          still_gap;

	// handshake
	assign in_stall  = (st_q != S_IDLE);
	assign in_acc    = in_valid && (st_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign detector_state = det_state_q;
	assign fall_flag = fall_q;
	assign magnitude = mag_out_q;

	// shift-add multiplier step
	assign mul_done     = (mul_b_q == '0);
	assign mul_acc_next = mul_b_q[0] ? (acc_q + mul_a_q) : acc_q;

	// square root step
	assign root_trial = {1'b0, res_q} + {1'b0, bit_q};
	assign root_take  = ({1'b0, rem_q} >= root_trial);
	assign res_next   = root_take ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	// pick the axis that follows the current one
	always_comb begin
		case (ax_idx_q)
			2'd0:    ax_next = abs16(ax_q[1]);
			2'd1:    ax_next = abs16(ax_q[2]);
			default: ax_next = abs16(ax_q[0]);
		endcase
	end

	// window arithmetic
	assign sum_push  = sum_q + SUM_W'(mag_q);
	assign fill_full = (fill_q == FILL_MAX);
	assign var_lhs   = (N_W * MUL_W'(sumsq_q)) - acc_q;
	assign var_rhs   = NN_W * MUL_W'(cfg_q.stillness_variance);
	assign is_still  = (var_lhs < var_rhs);

	// elapsed times, wrapping
	assign ff_gap    = t_q - ff_stamp_q;
	assign imp_gap   = t_q - imp_stamp_q;
	assign still_gap = t_q - still_stamp_q;

	// window store: write on push, read the oldest entry every cycle
	always_ff @(posedge clk) begin
		if (st_q == S_PUSH) begin
			window_q[pos_q] <= mag_q;
		end
		old_q <= window_q[pos_q];
	end

	// sequencer, detector state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q         <= CFG_RESET;
			st_q          <= S_IDLE;
			phase_q       <= PH_IDLE;
			ff_stamp_q    <= '0;
			imp_stamp_q   <= '0;
			still_stamp_q <= '0;
			still_trk_q   <= 1'b0;
			fill_q        <= '0;
			pos_q         <= '0;
			sum_q         <= '0;
			sumsq_q       <= '0;
			ax_q[0]       <= '0;
			ax_q[1]       <= '0;
			ax_q[2]       <= '0;
			ax_idx_q      <= '0;
			t_q           <= '0;
			mul_a_q       <= '0;
			mul_b_q       <= '0;
			acc_q         <= '0;
			rem_q         <= '0;
			res_q         <= '0;
			bit_q         <= '0;
			iter_q        <= '0;
			mag_q         <= '0;
			out_valid_q   <= 1'b0;
			det_state_q   <= CODE_IDLE;
			fall_q        <= 1'b0;
			mag_out_q     <= '0;
		end else begin
			// register writes keep the low 16 bits, all 32 for the stillness variance
			if (cfg_we) begin
				case (cfg_index)
					REG_FREEFALL_LEVEL:     cfg_q.freefall_level     <= cfg_data[15:0];
					REG_IMPACT_LEVEL:       cfg_q.impact_level       <= cfg_data[15:0];
					REG_IMPACT_WINDOW_MS:   cfg_q.impact_window_ms   <= cfg_data[15:0];
					REG_STILLNESS_VARIANCE: cfg_q.stillness_variance <= cfg_data[31:0];
					REG_STILLNESS_MS:       cfg_q.stillness_ms       <= cfg_data[15:0];
					REG_RECOVERY_MS:        cfg_q.recovery_ms        <= cfg_data[15:0];
					default: ;
				endcase
			end

			// drop the output beat once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && (st_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end

			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						t_q      <= time_ms;
						ax_q[0]  <= accel_x;
						ax_q[1]  <= accel_y;
						ax_q[2]  <= accel_z;
						ax_idx_q <= 2'd0;
						acc_q    <= '0;
						mul_a_q  <= MUL_W'(abs16(accel_x));
						mul_b_q  <= SUM_W'(abs16(accel_x));
						if (req_type) begin
							phase_q       <= PH_IDLE;
							ff_stamp_q    <= '0;
							imp_stamp_q   <= '0;
							still_stamp_q <= '0;
							still_trk_q   <= 1'b0;
							fill_q        <= '0;
							pos_q         <= '0;
							sum_q         <= '0;
							sumsq_q       <= '0;
							mag_q         <= '0;
							st_q          <= S_EMIT;
						end else begin
							st_q <= S_SQ;
						end
					end
				end

				// accumulate the three axis squares
				S_SQ: begin
					if (!mul_done) begin
						acc_q   <= mul_acc_next;
						mul_a_q <= mul_a_q << 1;
						mul_b_q <= mul_b_q >> 1;
					end else if (ax_idx_q == 2'd2) begin
						rem_q  <= acc_q[31:0];
						res_q  <= '0;
						bit_q  <= 32'h4000_0000;
						iter_q <= '0;
						st_q   <= S_ROOT;
					end else begin
						ax_idx_q <= ax_idx_q + 2'd1;
						mul_a_q  <= MUL_W'(ax_next);
						mul_b_q  <= SUM_W'(ax_next);
					end
				end

				// one result bit per cycle
				S_ROOT: begin
					if (root_take) begin
						rem_q <= rem_q - root_trial[31:0];
					end
					res_q  <= res_next;
					bit_q  <= bit_q >> 2;
					iter_q <= iter_q + 4'd1;
					if (iter_q == ITER_END) begin
						mag_q <= res_next[15:0];
						st_q  <= S_DECIDE;
					end
				end

				S_DECIDE: begin
					case (phase_q)
						PH_IDLE: begin
							if (mag_q < cfg_q.freefall_level) begin
								phase_q    <= PH_FREEFALL;
								ff_stamp_q <= t_q;
							end
							st_q <= S_EMIT;
						end
						PH_FREEFALL: begin
							if (mag_q > cfg_q.impact_level) begin
								phase_q       <= PH_IMPACT;
								imp_stamp_q   <= t_q;
								fill_q        <= '0;
								pos_q         <= '0;
								sum_q         <= '0;
								sumsq_q       <= '0;
								still_stamp_q <= '0;
								still_trk_q   <= 1'b0;
							end else if (ff_gap > 32'(cfg_q.impact_window_ms)) begin
								phase_q <= PH_IDLE;
							end
							st_q <= S_EMIT;
						end
						PH_IMPACT: begin
							acc_q <= '0;
							if (fill_full) begin
								mul_a_q <= MUL_W'(old_q);
								mul_b_q <= SUM_W'(old_q);
								st_q    <= S_OSQ;
							end else begin
								mul_a_q <= MUL_W'(mag_q);
								mul_b_q <= SUM_W'(mag_q);
								st_q    <= S_MSQ;
							end
						end
						default: begin
							st_q <= S_EMIT;
						end
					endcase
				end

				// retire the oldest entry
				S_OSQ: begin
					if (!mul_done) begin
						acc_q   <= mul_acc_next;
						mul_a_q <= mul_a_q << 1;
						mul_b_q <= mul_b_q >> 1;
					end else begin
						sumsq_q <= sumsq_q - acc_q[SUMSQ_W-1:0];
						sum_q   <= sum_q - SUM_W'(old_q);
						acc_q   <= '0;
						mul_a_q <= MUL_W'(mag_q);
						mul_b_q <= SUM_W'(mag_q);
						st_q    <= S_MSQ;
					end
				end

				// add the new square
				S_MSQ: begin
					if (!mul_done) begin
						acc_q   <= mul_acc_next;
						mul_a_q <= mul_a_q << 1;
						mul_b_q <= mul_b_q >> 1;
					end else begin
						sumsq_q <= sumsq_q + acc_q[SUMSQ_W-1:0];
						st_q    <= S_PUSH;
					end
				end

				// store the magnitude and advance the window
				S_PUSH: begin
					sum_q <= sum_push;
					if (!fill_full) begin
						fill_q <= fill_q + FILL_W'(1);
					end
					pos_q <= (pos_q == POS_MAX) ? '0 : (pos_q + WIN_AW'(1));
					if (fill_full || (fill_q == FILL_PRE)) begin
						acc_q   <= '0;
						mul_a_q <= MUL_W'(sum_push);
						mul_b_q <= sum_push;
						st_q    <= S_SSQ;
					end else begin
						st_q <= S_EMIT;
					end
				end

				S_SSQ: begin
					if (!mul_done) begin
						acc_q   <= mul_acc_next;
						mul_a_q <= mul_a_q << 1;
						mul_b_q <= mul_b_q >> 1;
					end else begin
						st_q <= S_VAR;
					end
				end

				// stillness and recovery tests on a full window
				S_VAR: begin
					if (is_still) begin
						if (!still_trk_q) begin
							still_trk_q   <= 1'b1;
							still_stamp_q <= t_q;
						end else if (still_gap >= 32'(cfg_q.stillness_ms)) begin
							phase_q <= PH_CONFIRMED;
						end
					end else begin
						still_trk_q   <= 1'b0;
						still_stamp_q <= '0;
						if (imp_gap > 32'(cfg_q.recovery_ms)) begin
							phase_q <= PH_IDLE;
							fill_q  <= '0;
							pos_q   <= '0;
							sum_q   <= '0;
							sumsq_q <= '0;
						end
					end
					st_q <= S_EMIT;
				end

				// hand the result to the output register
				S_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						det_state_q <= phase_code(phase_q);
						fall_q      <= (phase_q == PH_CONFIRMED);
						mag_out_q   <= mag_q;
						st_q        <= S_IDLE;
					end
				end

				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// an accepted beat always occupies the sequencer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (st_q != S_IDLE))
		else $error("sequencer idle right after an accepted beat");

	// confirmed phase is left only through a clear
	a_confirmed_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == PH_CONFIRMED) && !(in_acc && req_type)) |=> (phase_q == PH_CONFIRMED))
		else $error("confirmed phase left without a clear");

	// fill count stays within the window
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("window fill count beyond window length");

	// an empty window carries no sums, apart from the square added just ahead of the first push
	a_empty_sums: assert property (@(posedge clk) disable iff (!arst_n)
		((fill_q == '0) && (st_q != S_PUSH)) |-> ((sum_q == '0) && (sumsq_q == '0)))
		else $error("empty window with nonzero sums");

	// flag matches the reported phase
	a_flag_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (fall_q == (det_state_q == CODE_CONFIRMED)))
		else $error("fall flag disagrees with detector state");

endmodule

// ===== dv/tb_accel_fall_detector.sv =====
// Self-checking testbench of the fall detector: directed cases, register edges, random falls.
module tb_accel_fall_detector;
	timeunit 1ns;
	timeprecision 1ps;
	import afd_pkg::*;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	// register indexes that decode to nothing
	localparam logic [CFG_AW-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_AW-1:0] REG_SPARE_B = 3'd7;

	localparam logic signed [15:0] AX_MIN = 16'sh8000;
	localparam logic signed [15:0] AX_MAX = 16'sh7FFF;

	typedef enum int {EP_STILL, EP_MOVE, EP_MIXED, EP_TIMEOUT, EP_NOISE} episode_t;

	typedef struct packed {
		logic [1:0]  state;
		logic        flag;
		logic [15:0] mag;
	} report_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CFG_AW-1:0]   cfg_index = '0;
	logic [CFG_DW-1:0]   cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic                req_type  = 1'b0;
	logic signed [15:0]  accel_x   = '0;
	logic signed [15:0]  accel_y   = '0;
	logic signed [15:0]  accel_z   = '0;
	logic [31:0]         time_ms   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          detector_state;
	logic                fall_flag;
	logic [15:0]         magnitude;

	int          error_count = 0;
	int          beats_sent  = 0;
	int          idle_pct    = 0;
	int          stall_pct   = 0;
	logic [31:0] clock_ms    = '0;

	report_t pending_reports[$];

	// detector shadow: registers and state
	cfg_t        shadow_cfg = CFG_RESET;
	logic [1:0]  det_phase  = CODE_IDLE;
	logic [31:0] ff_stamp   = '0;
	logic [31:0] hit_stamp  = '0;
	logic [31:0] calm_stamp = '0;
	logic        calm_on    = 1'b0;
	logic [15:0] mag_ring [WIN_LEN];
	int unsigned ring_fill  = 0;
	int unsigned ring_pos   = 0;
	logic [63:0] ring_sum   = '0;
	logic [63:0] ring_sumsq = '0;

	accel_fall_detector u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.accel_x        (accel_x),
		.accel_y        (accel_y),
		.accel_z        (accel_z),
		.time_ms        (time_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.detector_state (detector_state),
		.fall_flag      (fall_flag),
		.magnitude      (magnitude)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// end the run if traffic stops moving
	initial begin
		#(20_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [31:0] axis_square(logic signed [15:0] a);
		logic signed [31:0] w;
		w = a;
		return w * w;
	endfunction

	// build the floor root one bit at a time, largest bit first
	function automatic logic [15:0] root_of(logic [31:0] v);
		logic [15:0] r;
		logic [15:0] c;
		r = '0;
		for (int b = 15; b >= 0; b--) begin
			c = r | (16'd1 << b);
			if (64'(c) * 64'(c) <= 64'(v))
				r = c;
		end
		return r;
	endfunction

	function automatic void ring_reset();
		ring_fill  = 0;
		ring_pos   = 0;
		ring_sum   = '0;
		ring_sumsq = '0;
	endfunction

	// drop the oldest magnitude once full, then add the new one
	function automatic void ring_push(logic [15:0] m);
		logic [63:0] old;
		if (ring_fill >= WIN_LEN) begin
			old = 64'(mag_ring[ring_pos]);
			ring_sum   -= old;
			ring_sumsq -= old * old;
		end else begin
			ring_fill++;
		end
		mag_ring[ring_pos] = m;
		ring_sum   += 64'(m);
		ring_sumsq += 64'(m) * 64'(m);
		ring_pos = (ring_pos + 1 == WIN_LEN) ? 0 : ring_pos + 1;
	endfunction

	// variance below the level, scaled by N squared to stay in integers
	function automatic logic ring_is_calm();
		logic [63:0] spread;
		logic [63:0] limit;
		spread = 64'(WIN_LEN) * ring_sumsq - ring_sum * ring_sum;
		limit  = 64'(shadow_cfg.stillness_variance) * 64'(WIN_LEN) * 64'(WIN_LEN);
		return spread < limit;
	endfunction

	function automatic void detector_reset();
		det_phase  = CODE_IDLE;
		ff_stamp   = '0;
		hit_stamp  = '0;
		calm_stamp = '0;
		calm_on    = 1'b0;
		ring_reset();
	endfunction

	function automatic void note_reg_write(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] d);
		case (idx)
			REG_FREEFALL_LEVEL:     shadow_cfg.freefall_level     = d[15:0];
			REG_IMPACT_LEVEL:       shadow_cfg.impact_level       = d[15:0];
			REG_IMPACT_WINDOW_MS:   shadow_cfg.impact_window_ms   = d[15:0];
			REG_STILLNESS_VARIANCE: shadow_cfg.stillness_variance = d;
			REG_STILLNESS_MS:       shadow_cfg.stillness_ms       = d[15:0];
			REG_RECOVERY_MS:        shadow_cfg.recovery_ms        = d[15:0];
			default: ;
		endcase
	endfunction

	// advance the shadow detector by one request and give the report it yields
	function automatic report_t predict_report(logic kind, logic signed [15:0] ax,
			logic signed [15:0] ay, logic signed [15:0] az, logic [31:0] t);
		report_t r;
		logic [15:0] m;
		m = '0;
		if (kind == REQ_CLEAR) begin
			detector_reset();
		end else begin
			m = root_of(axis_square(ax) + axis_square(ay) + axis_square(az));
			case (det_phase)
				CODE_IDLE: begin
					if (m < shadow_cfg.freefall_level) begin
						det_phase = CODE_FREEFALL;
						ff_stamp  = t;
					end
				end
				CODE_FREEFALL: begin
					if (m > shadow_cfg.impact_level) begin
						det_phase  = CODE_IMPACT;
						hit_stamp  = t;
						calm_stamp = '0;
						calm_on    = 1'b0;
						ring_reset();
					end else if (32'(t - ff_stamp) > 32'(shadow_cfg.impact_window_ms)) begin
						det_phase = CODE_IDLE;
					end
				end
				CODE_IMPACT: begin
					ring_push(m);
					if (ring_fill >= WIN_LEN) begin
						if (ring_is_calm()) begin
							if (!calm_on) begin
								calm_on    = 1'b1;
								calm_stamp = t;
							end else if (32'(t - calm_stamp) >= 32'(shadow_cfg.stillness_ms)) begin
								det_phase = CODE_CONFIRMED;
							end
						end else begin
							calm_on    = 1'b0;
							calm_stamp = '0;
							if (32'(t - hit_stamp) > 32'(shadow_cfg.recovery_ms)) begin
								det_phase = CODE_IDLE;
								ring_reset();
							end
						end
					end
				end
				default: ;
			endcase
		end
		r.state = det_phase;
		r.flag  = (det_phase == CODE_CONFIRMED);
		r.mag   = m;
		return r;
	endfunction

	function automatic void flag_error(string what, int want_v, int got_v);
		error_count++;
		if (error_count <= 10)
			$display("mismatch on %s: expected %0d, got %0d at %0t ns", what, want_v, got_v, $time);
	endfunction

	function automatic logic signed [15:0] jitter(int span);
		int v;
		v = int'($urandom_range(2 * span)) - span;
		return 16'(v);
	endfunction

	function automatic logic signed [15:0] with_sign(int v);
		return ($urandom_range(1) != 0) ? 16'(v) : 16'(-v);
	endfunction

	// check each delivered beat against the oldest pending report, then pick the next stall
	always @(posedge clk) begin
		report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				flag_error("unrequested result state", -1, detector_state);
			end else begin
				want = pending_reports.pop_front();
				if (detector_state !== want.state)
					flag_error("detector_state", want.state, detector_state);
				if (fall_flag !== want.flag)
					flag_error("fall_flag", want.flag, fall_flag);
				if (magnitude !== want.mag)
					flag_error("magnitude", want.mag, magnitude);
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// hold off at random, present one beat, wait for it to be taken
	task automatic send_item(input logic kind, input logic signed [15:0] ax,
			input logic signed [15:0] ay, input logic signed [15:0] az, input logic [31:0] t);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		accel_x  <= ax;
		accel_y  <= ay;
		accel_z  <= az;
		time_ms  <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_reports.push_back(predict_report(kind, ax, ay, az, t));
		beats_sent++;
	endtask

	// clear with junk in the ignored fields
	task automatic send_clear();
		send_item(REQ_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
	endtask

	task automatic wait_for_reports();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		note_reg_write(idx, d);
	endtask

	// write every register with junk above the narrow ones, plus a dead index
	task automatic load_settings(input cfg_t c);
		write_reg(REG_FREEFALL_LEVEL,     {16'($urandom), c.freefall_level});
		write_reg(REG_IMPACT_LEVEL,       {16'($urandom), c.impact_level});
		write_reg(REG_IMPACT_WINDOW_MS,   {16'($urandom), c.impact_window_ms});
		write_reg(REG_STILLNESS_VARIANCE, c.stillness_variance);
		write_reg(REG_STILLNESS_MS,       {16'($urandom), c.stillness_ms});
		write_reg(REG_RECOVERY_MS,        {16'($urandom), c.recovery_ms});
		write_reg(($urandom_range(1) != 0) ? REG_SPARE_A : REG_SPARE_B, $urandom);
		cfg_we <= 1'b0;
	endtask

	// one lead-in at rest, a drop, then impact and what follows, or a timeout or noise
	task automatic run_episode(input episode_t kind);
		int base;
		int guard;
		int fall_span;
		int radius;
		logic jolt;
		if (kind == EP_NOISE) begin
			repeat ($urandom_range(5, 12)) begin
				clock_ms += $urandom_range(0, 400);
				send_item(($urandom_range(9) == 0) ? REQ_CLEAR : REQ_SAMPLE, 16'($urandom),
					16'($urandom), 16'($urandom),
					($urandom_range(3) == 0) ? $urandom : clock_ms);
			end
		end else begin
			repeat ($urandom_range(0, 3)) begin
				clock_ms += $urandom_range(1, 50);
				send_item(REQ_SAMPLE, with_sign($urandom_range(3000, 9000)), jitter(2000),
					jitter(2000), clock_ms);
			end
			fall_span = shadow_cfg.impact_window_ms / 4;
			radius = shadow_cfg.freefall_level / 4;
			if (radius > 4000)
				radius = 4000;
			repeat ($urandom_range(1, 3)) begin
				clock_ms += $urandom_range(0, fall_span);
				send_item(REQ_SAMPLE, jitter(radius), jitter(radius), jitter(radius), clock_ms);
			end
			if (kind == EP_TIMEOUT) begin
				// stay moderate until the impact window runs out
				guard = 0;
				while (det_phase == CODE_FREEFALL && guard < 20) begin
					guard++;
					clock_ms += $urandom_range(0, 2 * fall_span + 1);
					send_item(REQ_SAMPLE, with_sign($urandom_range(3000, 9000)), jitter(2000),
						jitter(2000), clock_ms);
				end
			end else begin
				clock_ms += $urandom_range(0, fall_span);
				send_item(REQ_SAMPLE, with_sign($urandom_range(30000, 32768)),
					with_sign($urandom_range(30000, 32768)),
					with_sign($urandom_range(30000, 32768)), clock_ms);
				// lie still, keep moving, or mostly still with jolts
				base = $urandom_range(500, 20000);
				guard = 0;
				while (det_phase == CODE_IMPACT && guard < 70) begin
					guard++;
					jolt = (kind == EP_MOVE) || (kind == EP_MIXED && $urandom_range(99) < 12);
					if (jolt) begin
						clock_ms += shadow_cfg.recovery_ms / 30 + $urandom_range(0, 3);
						send_item(REQ_SAMPLE, with_sign($urandom_range(0, 32768)), jitter(16000),
							jitter(16000), clock_ms);
					end else begin
						clock_ms += shadow_cfg.stillness_ms / 6 + $urandom_range(0, 3);
						send_item(REQ_SAMPLE, with_sign(base + int'(jitter(6))), jitter(6),
							jitter(6), clock_ms);
					end
				end
				repeat ($urandom_range(0, 3)) begin
					clock_ms += $urandom_range(0, 1000);
					send_item(REQ_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom), clock_ms);
				end
			end
		end
		if (det_phase == CODE_CONFIRMED || $urandom_range(99) < 30)
			send_clear();
	endtask

	// field extremes, threshold equalities, impact ahead of timeout, clears, wrapped time
	task automatic test_directed_cases();
		send_item(REQ_SAMPLE, AX_MIN, AX_MIN, AX_MIN, 32'd100);
		send_item(REQ_SAMPLE, AX_MAX, AX_MAX, AX_MAX, 32'd110);
		send_item(REQ_SAMPLE, 16'sd2048, 16'sd0, 16'sd0, 32'd120);
		send_item(REQ_SAMPLE, -16'sd2047, 16'sd0, 16'sd0, 32'd1000);
		send_item(REQ_SAMPLE, 16'sd10240, 16'sd0, 16'sd0, 32'd1100);
		send_item(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd1300);
		send_item(REQ_SAMPLE, 16'sd5000, 16'sd0, 16'sd0, 32'd1301);
		send_item(REQ_SAMPLE, 16'sd0, 16'sd0, -16'sd1, 32'd2000);
		// late but hard enough: impact wins over the timeout
		send_item(REQ_SAMPLE, -16'sd10241, 16'sd0, 16'sd0, 32'd2500);
		send_clear();
		send_clear();
		// time gaps across the 32-bit wrap
		send_item(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'hFFFF_FF80);
		send_item(REQ_SAMPLE, 16'sd4000, 16'sd0, 16'sd0, 32'h0000_0000);
		send_item(REQ_SAMPLE, 16'sd4000, 16'sd0, 16'sd0, 32'h0000_00AD);
		send_item(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'hFFFF_FFF0);
		send_item(REQ_SAMPLE, AX_MAX, AX_MAX, AX_MIN, 32'd5);
		send_item(REQ_SAMPLE, 16'sd100, 16'sd200, 16'sd300, 32'd15);
		send_item(REQ_SAMPLE, -16'sd100, 16'sd200, -16'sd300, 32'd25);
		send_clear();
		send_item(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd40);
		send_clear();
	endtask

	// zero and full-scale levels and a zero impact window
	task automatic test_register_edges();
		cfg_t c;
		wait_for_reports();
		c = CFG_RESET;
		c.freefall_level   = 16'd0;
		c.impact_level     = 16'hFFFF;
		c.impact_window_ms = 16'd0;
		load_settings(c);
		send_item(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd50);
		wait_for_reports();
		c.freefall_level = 16'hFFFF;
		load_settings(c);
		send_item(REQ_SAMPLE, AX_MIN, AX_MIN, AX_MIN, 32'd60);
		send_item(REQ_SAMPLE, AX_MIN, AX_MIN, AX_MIN, 32'd60);
		send_item(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd61);
		wait_for_reports();
		c.impact_level = 16'd0;
		load_settings(c);
		send_item(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd70);
		send_item(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd70);
		send_item(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd1, 32'd70);
		send_clear();
		wait_for_reports();
		load_settings(CFG_RESET);
	endtask

	// random fall episodes under one register setting and one idling mix
	task automatic test_random_falls(input int send_gap_pct, input int hold_pct, input cfg_t c,
			input int quota);
		int start;
		int roll;
		wait_for_reports();
		load_settings(c);
		idle_pct  = send_gap_pct;
		stall_pct = hold_pct;
		clock_ms  = $urandom;
		start     = beats_sent;
		while (beats_sent - start < quota) begin
			roll = $urandom_range(99);
			if (roll < 45)
				run_episode(EP_STILL);
			else if (roll < 65)
				run_episode(EP_MOVE);
			else if (roll < 80)
				run_episode(EP_MIXED);
			else if (roll < 90)
				run_episode(EP_TIMEOUT);
			else
				run_episode(EP_NOISE);
		end
	endtask

	initial begin
		cfg_t set_a;
		cfg_t set_b;
		cfg_t set_c;
		cfg_t set_d;
		set_a = '{freefall_level: 16'd2048, impact_level: 16'd10240, impact_window_ms: 16'd300,
			stillness_variance: 32'd4096, stillness_ms: 16'd200, recovery_ms: 16'd1500};
		set_b = '{freefall_level: 16'hFFFF, impact_level: 16'd0, impact_window_ms: 16'd0,
			stillness_variance: 32'hFFFF_FFFF, stillness_ms: 16'd0, recovery_ms: 16'd0};
		set_c = '{freefall_level: 16'd3000, impact_level: 16'd40000, impact_window_ms: 16'hFFFF,
			stillness_variance: 32'd0, stillness_ms: 16'hFFFF, recovery_ms: 16'hFFFF};
		set_d.freefall_level     = 16'($urandom_range(1000, 8000));
		set_d.impact_level       = 16'($urandom_range(12000, 50000));
		set_d.impact_window_ms   = 16'($urandom_range(50, 2000));
		set_d.stillness_variance = $urandom_range(16, 100000);
		set_d.stillness_ms       = 16'($urandom_range(0, 3000));
		set_d.recovery_ms        = 16'($urandom_range(500, 20000));

		// hold reset, then release
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_register_edges();
		test_random_falls(0, 0, set_a, 195);
		test_random_falls(66, 0, set_b, 195);
		test_random_falls(0, 66, set_c, 195);
		test_random_falls(34, 34, set_d, 195);

		// drain, then watch for stray beats
		wait_for_reports();
		repeat (200) @(posedge clk);
		if (error_count == 0 && pending_reports.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
